// File: rtl/mobs_pkg.sv
// ----------------------------------------------------------------------------
// Market order book sweep package
// Shared widths, constants and state type for the order book sweep block.
// ----------------------------------------------------------------------------
package mobs_pkg;

  localparam int unsigned LEVELS  = 32;
  localparam int unsigned LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned CNT_W   = $clog2(LEVELS + 1);
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned PRICE_W = 24;
  localparam int unsigned VOL_W   = 24;
  localparam int unsigned POS_W   = 48;
  localparam int unsigned CASH_W  = 64;
  localparam int unsigned ORD_W   = 32;
  localparam int unsigned COST_W  = 64;
  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned DCNT_W  = $clog2(DIV_STEPS + 1);

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_ORDER = 1'b1;
  localparam logic SIDE_ASK   = 1'b0;
  localparam logic SIDE_BID   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_RDWAIT,
    ST_MUL,
    ST_ACC,
    ST_DIV,
    ST_UPD,
    ST_MRD,
    ST_MRDWAIT,
    ST_MARK,
    ST_MARK2,
    ST_MADD,
    ST_OUT
  } state_t;

endpackage

// File: rtl/mobs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module mobs_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/market_order_book_sweep_top.sv
// ----------------------------------------------------------------------------
// Market order book sweep
// A load or a skipped order goes to marking (ST_MRD, ST_MRDWAIT, ST_MARK,
// ST_MARK2, ST_MADD) and raises out_valid in ST_OUT. An order first sweeps up
// to 32 levels, each through ST_RD, ST_RDWAIT, ST_MUL and ST_ACC, then runs the
// restoring division in ST_DIV (left at once if nothing is filled) and ST_UPD.
// One transaction is in work at a time; ready is low until its result is taken.
// Reset is synchronous, active low; it clears the volume valid bits and state.
// ----------------------------------------------------------------------------
module market_order_book_sweep_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_func,
  input  logic                          in_side,
  input  logic [mobs_pkg::IDX_W-1:0]    in_level_index,
  input  logic [mobs_pkg::PRICE_W-1:0]  in_level_price,
  input  logic [mobs_pkg::VOL_W-1:0]    in_amount,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mobs_pkg::VOL_W-1:0]    out_filled_volume,
  output logic [mobs_pkg::PRICE_W-1:0]  out_avg_fill_price,
  output logic [mobs_pkg::VOL_W-1:0]    out_unfilled_volume,
  output logic                          out_skipped,
  output logic signed [mobs_pkg::POS_W-1:0]  out_net_position,
  output logic signed [mobs_pkg::CASH_W-1:0] out_cash_balance,
  output logic signed [mobs_pkg::CASH_W-1:0] out_marked_pnl,
  output logic [mobs_pkg::ORD_W-1:0]    out_orders_done
);
  import mobs_pkg::*;

  state_t state_r, state_nxt;

  logic             side_r;
  logic [VOL_W-1:0] rem_r;
  logic [CNT_W-1:0] lvl_r;
  logic [COST_W-1:0] cost_r;
  logic [VOL_W-1:0] filled_r;
  logic [VOL_W-1:0] take_r;
  logic [PRICE_W-1:0] price_r;
  logic [47:0]      prod_r;
  logic [COST_W-1:0] quo_r, divrem_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic             loaded_r;
  logic signed [POS_W-1:0]  pos_r;
  logic signed [CASH_W-1:0] cash_r;
  logic [ORD_W-1:0] ord_r;
  logic [LEVELS-1:0] ask_vld_r, bid_vld_r;
  logic [71:0]      mprod_r;
  logic             mneg_r;

  logic [VOL_W-1:0] o_filled_r, o_avg_r, o_unf_r;
  logic             o_skip_r;
  logic signed [CASH_W-1:0] o_pnl_r;

  // RAM ports
  logic             ap_we, av_we, bp_we, bv_we;
  logic [LVL_W-1:0] wa, ra;
  logic [VOL_W-1:0] vol_wd;
  logic [PRICE_W-1:0] ap_rd, bp_rd;
  logic [VOL_W-1:0] av_rd, bv_rd;

  logic accept;
  assign accept = in_valid && in_ready;

  logic idx_ok;
  assign idx_ok = ({3'b000, in_level_index} < 8'(LEVELS));

  logic lvl_vld;
  assign lvl_vld = side_r ? bid_vld_r[lvl_r[LVL_W-1:0]] : ask_vld_r[lvl_r[LVL_W-1:0]];

  logic [VOL_W-1:0] rd_vol, rd_price;
  assign rd_vol   = lvl_vld ? (side_r ? bv_rd : av_rd) : '0;
  assign rd_price = lvl_vld ? (side_r ? bp_rd : ap_rd) : '0;

  logic [VOL_W-1:0] take_c;
  assign take_c = (rd_vol > rem_r) ? rem_r : rd_vol;

  always_comb begin
    ap_we = 1'b0; av_we = 1'b0; bp_we = 1'b0; bv_we = 1'b0;
    wa = in_level_index[LVL_W-1:0];
    vol_wd = in_amount;
    ra = lvl_r[LVL_W-1:0];
    if (accept && in_func == FUNC_LOAD && idx_ok) begin
      ap_we = (in_side == SIDE_ASK);
      av_we = (in_side == SIDE_ASK);
      bp_we = (in_side == SIDE_BID);
      bv_we = (in_side == SIDE_BID);
    end else if (state_r == ST_ACC) begin
      wa = lvl_r[LVL_W-1:0];
      vol_wd = rd_vol - take_r;
      av_we = (side_r == SIDE_ASK) && lvl_vld;
      bv_we = (side_r == SIDE_BID) && lvl_vld;
    end
    if (state_r == ST_MRD || state_r == ST_MRDWAIT) begin
      ra = '0;
    end
  end

  mobs_ram #(.WIDTH(PRICE_W), .DEPTH(LEVELS)) u_ask_price (
    .clk(clk), .we(ap_we), .waddr(wa), .wdata(in_level_price), .raddr(ra), .rdata(ap_rd));
  mobs_ram #(.WIDTH(VOL_W), .DEPTH(LEVELS)) u_ask_vol (
    .clk(clk), .we(av_we), .waddr(wa), .wdata(vol_wd), .raddr(ra), .rdata(av_rd));
  mobs_ram #(.WIDTH(PRICE_W), .DEPTH(LEVELS)) u_bid_price (
    .clk(clk), .we(bp_we), .waddr(wa), .wdata(in_level_price), .raddr(ra), .rdata(bp_rd));
  mobs_ram #(.WIDTH(VOL_W), .DEPTH(LEVELS)) u_bid_vol (
    .clk(clk), .we(bv_we), .waddr(wa), .wdata(vol_wd), .raddr(ra), .rdata(bv_rd));

  // Division step: restoring trial subtractor.
  logic [COST_W:0] dtrial;
  logic [COST_W-1:0] dshift;
  assign dshift = {divrem_r[COST_W-2:0], cost_r[COST_W-1]};
  assign dtrial = {divrem_r, cost_r[COST_W-1]} - {{(COST_W-VOL_W+1){1'b0}}, filled_r};

  // Saturating position and cash update.
  logic signed [POS_W:0] pos_sum;
  logic signed [POS_W-1:0] pos_new;
  logic signed [CASH_W:0] cash_sum;
  logic signed [CASH_W-1:0] cash_new;
  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic signed [CASH_W-1:0] CASH_MAX = {1'b0, {(CASH_W-1){1'b1}}};
  localparam logic signed [CASH_W-1:0] CASH_MIN = {1'b1, {(CASH_W-1){1'b0}}};

  always_comb begin
    if (side_r == SIDE_ASK) begin
      pos_sum  = {pos_r[POS_W-1], pos_r} + $signed({{(POS_W-VOL_W+1){1'b0}}, filled_r});
      cash_sum = {cash_r[CASH_W-1], cash_r} - $signed({1'b0, quo_r});
    end else begin
      pos_sum  = {pos_r[POS_W-1], pos_r} - $signed({{(POS_W-VOL_W+1){1'b0}}, filled_r});
      cash_sum = {cash_r[CASH_W-1], cash_r} + $signed({1'b0, quo_r});
    end
    if (pos_sum[POS_W] != pos_sum[POS_W-1]) begin
      pos_new = pos_sum[POS_W] ? POS_MIN : POS_MAX;
    end else begin
      pos_new = pos_sum[POS_W-1:0];
    end
    if (cash_sum[CASH_W] != cash_sum[CASH_W-1]) begin
      cash_new = cash_sum[CASH_W] ? CASH_MIN : CASH_MAX;
    end else begin
      cash_new = cash_sum[CASH_W-1:0];
    end
  end

  // Marking: magnitude of position times price, up to 72 bits.
  logic [POS_W-1:0] pos_mag;
  assign pos_mag = pos_r[POS_W-1] ? POS_W'(-pos_r) : POS_W'(pos_r);

  // Shared 24 by 24 multiplier: level cost during the sweep, then the low and
  // high halves of the position magnitude during marking.
  logic [VOL_W-1:0]         mul_a;
  logic [PRICE_W-1:0]       mul_b;
  logic [VOL_W+PRICE_W-1:0] mul_p;
  always_comb begin
    mul_a = take_c;
    mul_b = rd_price;
    if (state_r == ST_MARK) begin
      mul_a = pos_mag[VOL_W-1:0];
      mul_b = pos_r[POS_W-1] ? ap_rd : bp_rd;
    end else if (state_r == ST_MARK2) begin
      mul_a = pos_mag[POS_W-1:VOL_W];
      mul_b = price_r;
    end
  end
  assign mul_p = mul_a * mul_b;

  logic signed [73:0] pnl_sum;
  logic signed [73:0] mterm;
  assign mterm   = mneg_r ? -$signed({2'b00, mprod_r}) : $signed({2'b00, mprod_r});
  assign pnl_sum = $signed({{10{cash_r[CASH_W-1]}}, cash_r}) + mterm;

  logic signed [CASH_W-1:0] pnl_sat;
  always_comb begin
    if (pnl_sum > $signed({{10{1'b0}}, CASH_MAX})) begin
      pnl_sat = CASH_MAX;
    end else if (pnl_sum < $signed({{10{1'b1}}, CASH_MIN})) begin
      pnl_sat = CASH_MIN;
    end else begin
      pnl_sat = pnl_sum[CASH_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_func == FUNC_ORDER && loaded_r) begin
            state_nxt = ST_RD;
          end else begin
            state_nxt = ST_MRD;
          end
        end
      end
      ST_RD: begin
        if (rem_r == '0 || lvl_r == CNT_W'(LEVELS)) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_RDWAIT;
        end
      end
      ST_RDWAIT: state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_ACC;
      ST_ACC:    state_nxt = ST_RD;
      ST_DIV: begin
        if (dcnt_r == DCNT_W'(DIV_STEPS) || filled_r == '0) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD:     state_nxt = ST_MRD;
      ST_MRD:     state_nxt = ST_MRDWAIT;
      ST_MRDWAIT: state_nxt = ST_MARK;
      ST_MARK:    state_nxt = ST_MARK2;
      ST_MARK2:   state_nxt = ST_MADD;
      ST_MADD:    state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    out_valid = (state_r == ST_OUT);
  end

  assign out_filled_volume   = o_filled_r;
  assign out_avg_fill_price  = o_avg_r;
  assign out_unfilled_volume = o_unf_r;
  assign out_skipped         = o_skip_r;
  assign out_net_position    = pos_r;
  assign out_cash_balance    = cash_r;
  assign out_marked_pnl      = o_pnl_r;
  assign out_orders_done     = ord_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      loaded_r  <= 1'b0;
      pos_r     <= '0;
      cash_r    <= '0;
      ord_r     <= '0;
      ask_vld_r <= '0;
      bid_vld_r <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            side_r     <= in_side;
            rem_r      <= in_amount;
            lvl_r      <= '0;
            cost_r     <= '0;
            filled_r   <= '0;
            o_filled_r <= '0;
            o_avg_r    <= '0;
            o_unf_r    <= '0;
            o_skip_r   <= 1'b0;
            if (in_func == FUNC_LOAD) begin
              loaded_r <= 1'b1;
              if (idx_ok) begin
                if (in_side == SIDE_ASK) begin
                  ask_vld_r[in_level_index[LVL_W-1:0]] <= 1'b1;
                end else begin
                  bid_vld_r[in_level_index[LVL_W-1:0]] <= 1'b1;
                end
              end
            end else if (!loaded_r) begin
              o_skip_r <= 1'b1;
              o_unf_r  <= in_amount;
            end
          end
        end
        ST_MUL: begin
          take_r  <= take_c;
          price_r <= rd_price;
          prod_r  <= mul_p;
        end
        ST_ACC: begin
          cost_r   <= cost_r + COST_W'(prod_r);
          filled_r <= filled_r + take_r;
          rem_r    <= rem_r - take_r;
          lvl_r    <= lvl_r + 1'b1;
        end
        ST_RD: begin
          if (state_nxt == ST_DIV) begin
            quo_r    <= cost_r;
            divrem_r <= '0;
            dcnt_r   <= '0;
          end
        end
        ST_DIV: begin
          if (filled_r != '0 && dcnt_r != DCNT_W'(DIV_STEPS)) begin
            dcnt_r <= dcnt_r + 1'b1;
            cost_r <= {cost_r[COST_W-2:0], ~dtrial[COST_W]};
            divrem_r <= dtrial[COST_W] ? dshift : dtrial[COST_W-1:0];
          end
        end
        ST_UPD: begin
          o_filled_r <= filled_r;
          o_avg_r    <= (filled_r == '0) ? '0 : cost_r[VOL_W-1:0];
          o_unf_r    <= rem_r;
          pos_r      <= pos_new;
          cash_r     <= cash_new;
          ord_r      <= ord_r + 1'b1;
        end
        ST_MARK: begin
          mneg_r  <= pos_r[POS_W-1];
          price_r <= mul_b;
          mprod_r <= {24'b0, mul_p};
        end
        ST_MARK2: begin
          mprod_r <= mprod_r + {mul_p, 24'b0};
        end
        ST_MADD: begin
          o_pnl_r <= (pos_r == '0) ? cash_r : pnl_sat;
        end
        default: begin
        end
      endcase
      if (state_r == ST_UPD) begin
        cost_r <= quo_r;
      end
    end
  end

endmodule

// File: tb/sv/market_order_book_sweep_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Order book sweep testbench
// Loads book levels and sends market orders through the valid/ready input,
// predicts every result with a bit-accurate book model in a scoreboard class,
// and checks each result transaction field by field, under random idling.
// ----------------------------------------------------------------------------
module market_order_book_sweep_top_tb;
  import mobs_pkg::*;

  typedef logic signed [129:0] wide_t;

  typedef struct {
    logic [VOL_W-1:0]          filled;
    logic [PRICE_W-1:0]        avg;
    logic [VOL_W-1:0]          unfilled;
    logic                      skipped;
    logic signed [POS_W-1:0]   position;
    logic signed [CASH_W-1:0]  cash;
    logic signed [CASH_W-1:0]  pnl;
    logic [ORD_W-1:0]          orders;
  } fill_report_t;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int ITEMS          = 1900;

  class book_scoreboard;
    logic [PRICE_W-1:0] ask_px[LEVELS];
    logic [VOL_W-1:0]   ask_vol[LEVELS];
    logic [PRICE_W-1:0] bid_px[LEVELS];
    logic [VOL_W-1:0]   bid_vol[LEVELS];
    bit                 loaded;
    wide_t              position;
    wide_t              cash;
    logic [ORD_W-1:0]   orders;
    fill_report_t       pending_q[$];
    int                 errors;
    int                 checked;
    int                 n_loads;
    int                 n_orders;
    int                 n_skips;
    int                 n_partial;

    function new();
      for (int i = 0; i < LEVELS; i++) begin
        ask_px[i] = '0;
        ask_vol[i] = '0;
        bid_px[i] = '0;
        bid_vol[i] = '0;
      end
      loaded = 0;
      position = 0;
      cash = 0;
      orders = '0;
      errors = 0;
      checked = 0;
    endfunction

    function wide_t clamp(wide_t v, wide_t hi);
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function void note(logic func, logic side, logic [IDX_W-1:0] idx,
                       logic [PRICE_W-1:0] px, logic [VOL_W-1:0] amount);
      fill_report_t r;
      logic [VOL_W-1:0] remaining;
      logic [VOL_W-1:0] take;
      logic [63:0] cost;
      logic [63:0] filled;
      wide_t mark_px;
      wide_t pos_max;
      wide_t cash_max;
      pos_max = (wide_t'(1) <<< 47) - 1;
      cash_max = (wide_t'(1) <<< 63) - 1;
      r.filled = '0;
      r.avg = '0;
      r.unfilled = '0;
      r.skipped = 0;
      if (func == FUNC_LOAD) begin
        n_loads++;
        if (idx < LEVELS) begin
          if (side == SIDE_ASK) begin
            ask_px[idx] = px;
            ask_vol[idx] = amount;
          end else begin
            bid_px[idx] = px;
            bid_vol[idx] = amount;
          end
        end
        loaded = 1;
      end else if (!loaded) begin
        n_skips++;
        r.skipped = 1;
        r.unfilled = amount;
      end else begin
        n_orders++;
        remaining = amount;
        cost = 0;
        filled = 0;
        for (int l = 0; l < LEVELS; l++) begin
          if (remaining == 0) break;
          take = (side == SIDE_ASK) ? ask_vol[l] : bid_vol[l];
          if (take == 0) continue;
          if (take > remaining) take = remaining;
          if (side == SIDE_ASK) begin
            cost += 64'(take) * 64'(ask_px[l]);
            ask_vol[l] -= take;
          end else begin
            cost += 64'(take) * 64'(bid_px[l]);
            bid_vol[l] -= take;
          end
          filled += 64'(take);
          remaining -= take;
        end
        if (remaining != 0) n_partial++;
        r.filled = filled[VOL_W-1:0];
        r.unfilled = remaining;
        r.avg = (filled != 0) ? 24'(cost / filled) : '0;
        if (side == SIDE_ASK) begin
          position = clamp(position + $signed({66'd0, filled}), pos_max);
          cash = clamp(cash - $signed({66'd0, cost}), cash_max);
        end else begin
          position = clamp(position - $signed({66'd0, filled}), pos_max);
          cash = clamp(cash + $signed({66'd0, cost}), cash_max);
        end
        orders = orders + 1'b1;
      end
      if (position > 0) mark_px = $signed({106'd0, bid_px[0]});
      else mark_px = $signed({106'd0, ask_px[0]});
      r.position = position[POS_W-1:0];
      r.cash = cash[CASH_W-1:0];
      r.pnl = 64'(clamp(cash + position * mark_px, cash_max));
      r.orders = orders;
      pending_q = {pending_q, r};
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch on result %0d, %s: got %0h, expected %0h", checked, what, got, want);
      errors++;
    endtask

    task check(fill_report_t g);
      fill_report_t e;
      if (pending_q.size() == 0) begin
        $display("result transaction with no outstanding item");
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (g.filled !== e.filled)
        report_mismatch("filled_volume", 64'(g.filled), 64'(e.filled));
      if (g.avg !== e.avg)
        report_mismatch("avg_fill_price", 64'(g.avg), 64'(e.avg));
      if (g.unfilled !== e.unfilled)
        report_mismatch("unfilled_volume", 64'(g.unfilled), 64'(e.unfilled));
      if (g.skipped !== e.skipped)
        report_mismatch("skipped", 64'(g.skipped), 64'(e.skipped));
      if (g.position !== e.position)
        report_mismatch("net_position", 64'(g.position), 64'(e.position));
      if (g.cash !== e.cash)
        report_mismatch("cash_balance", 64'(g.cash), 64'(e.cash));
      if (g.pnl !== e.pnl)
        report_mismatch("marked_pnl", 64'(g.pnl), 64'(e.pnl));
      if (g.orders !== e.orders)
        report_mismatch("orders_done", 64'(g.orders), 64'(e.orders));
      checked++;
    endtask
  endclass

  logic                      clk = 0;
  logic                      rst_n = 0;
  logic                      in_valid = 0;
  logic                      in_ready;
  logic                      in_func = 0;
  logic                      in_side = 0;
  logic [IDX_W-1:0]          in_level_index = '0;
  logic [PRICE_W-1:0]        in_level_price = '0;
  logic [VOL_W-1:0]          in_amount = '0;
  logic                      out_valid;
  logic                      out_ready = 0;
  logic [VOL_W-1:0]          out_filled_volume;
  logic [PRICE_W-1:0]        out_avg_fill_price;
  logic [VOL_W-1:0]          out_unfilled_volume;
  logic                      out_skipped;
  logic signed [POS_W-1:0]   out_net_position;
  logic signed [CASH_W-1:0]  out_cash_balance;
  logic signed [CASH_W-1:0]  out_marked_pnl;
  logic [ORD_W-1:0]          out_orders_done;

  book_scoreboard sb = new();
  bit   steady = 1;
  bit   hold_request = 0;
  int   idle_cycles = 0;

  always #4 clk = ~clk;

  market_order_book_sweep_top DUT (.*);

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send(logic func, logic side, logic [IDX_W-1:0] idx,
                      logic [PRICE_W-1:0] px, logic [VOL_W-1:0] amount);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_func <= func;
    in_side <= side;
    in_level_index <= idx;
    in_level_price <= px;
    in_amount <= amount;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random();
    logic [IDX_W-1:0] idx;
    logic [VOL_W-1:0] amt;
    if ($urandom_range(0, 99) < 45) begin
      idx = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
      case ($urandom_range(0, 9))
        0: amt = '0;
        1: amt = '1;
        2, 3: amt = 24'($urandom);
        default: amt = 24'($urandom_range(1, 5000));
      endcase
      send(FUNC_LOAD, 1'($urandom), idx,
           ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 4000)), amt);
    end else begin
      case ($urandom_range(0, 9))
        0: amt = '0;
        1: amt = 24'($urandom);
        default: amt = 24'($urandom_range(1, 8000));
      endcase
      send(FUNC_ORDER, 1'($urandom), 5'($urandom), 24'($urandom), amt);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note(in_func, in_side, in_level_index, in_level_price, in_amount);
  end

  always @(posedge clk) begin
    fill_report_t g;
    if (rst_n && out_valid && out_ready) begin
      g.filled = out_filled_volume;
      g.avg = out_avg_fill_price;
      g.unfilled = out_unfilled_volume;
      g.skipped = out_skipped;
      g.position = out_net_position;
      g.cash = out_cash_balance;
      g.pnl = out_marked_pnl;
      g.orders = out_orders_done;
      sb.check(g);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", idle_cycles);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int r;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (hold_request) begin
        hold_request = 0;
        out_ready <= 0;
        repeat (1500) @(posedge clk);
      end else if (steady || r < 60) begin
        out_ready <= 1;
        @(posedge clk);
      end else if (r < 95) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ready <= 0;
        repeat ($urandom_range(10, 80)) @(posedge clk);
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send(FUNC_ORDER, SIDE_ASK, 5'd31, 24'hFFFFFF, 24'hFFFFFF);
    send(FUNC_ORDER, SIDE_BID, 5'd0, 24'h0, 24'h0);
    send(FUNC_LOAD, SIDE_ASK, 5'd0, 24'd1000, 24'd10);
    send(FUNC_LOAD, SIDE_BID, 5'd0, 24'd990, 24'd10);
    send(FUNC_LOAD, SIDE_ASK, 5'd31, 24'hFFFFFF, 24'hFFFFFF);
    send(FUNC_LOAD, SIDE_BID, 5'd31, 24'h0, 24'hFFFFFF);
    send(FUNC_LOAD, SIDE_ASK, 5'd2, 24'h0, 24'h0);
    send(FUNC_ORDER, SIDE_ASK, 5'd17, 24'h5A5A5A, 24'h0);
    send(FUNC_ORDER, SIDE_ASK, 5'd0, 24'h0, 24'd4);
    send(FUNC_ORDER, SIDE_ASK, 5'd0, 24'h0, 24'd20);
    send(FUNC_ORDER, SIDE_ASK, 5'd0, 24'h0, 24'hFFFFFF);
    send(FUNC_ORDER, SIDE_BID, 5'd0, 24'hFFFFFF, 24'd5);
    send(FUNC_ORDER, SIDE_BID, 5'd0, 24'h0, 24'hFFFFFF);
    send(FUNC_ORDER, SIDE_BID, 5'd0, 24'h0, 24'd3);
    send(FUNC_LOAD, SIDE_ASK, 5'd0, 24'hFFFFFF, 24'hFFFFFF);
    send(FUNC_LOAD, SIDE_BID, 5'd0, 24'hFFFFFF, 24'hFFFFFF);
    send(FUNC_ORDER, SIDE_ASK, 5'd0, 24'h0, 24'hFFFFFF);
    send(FUNC_ORDER, SIDE_BID, 5'd0, 24'h0, 24'hFFFFFF);
    send(FUNC_ORDER, SIDE_BID, 5'd0, 24'h0, 24'h800000);

    for (int i = 0; i < ITEMS; i++) begin
      if (i % 250 == 0) steady = ($urandom_range(0, 3) == 0);
      if (i == 600) begin
        steady = 0;
        hold_request = 1;
      end
      if (i == 1200) begin
        in_valid <= 0;
        @(posedge clk);
        while (sb.pending_q.size() != 0) @(posedge clk);
      end
      send_random();
    end
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Covered %0d loads, %0d executed orders (%0d left partly unfilled), %0d skipped.",
             sb.n_loads, sb.n_orders, sb.n_partial, sb.n_skips);
    $display("Checked %0d results with %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
